[rtl/aging_priority_task_scheduler_top_assert.svh]
// assertion macros for the aging priority task scheduler
`ifndef AGING_PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH
`define AGING_PRIORITY_TASK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define APTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication, checked outside reset
`define APTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

[rtl/apts_pkg.sv]
// ----------------------------------------------------------------------------
// apts_pkg
// Types and constants shared by the aging priority task scheduler.
// ----------------------------------------------------------------------------
package apts_pkg;

  localparam int SLOT_W = 4;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 32;
  localparam int EFF_W  = 33;
  localparam int CFG_W  = 8;

  // configuration register indexes
  localparam logic CFG_SLICE_RELOAD = 1'b0;
  localparam logic CFG_AGE_SHIFT    = 1'b1;

  localparam logic [7:0] SLICE_RELOAD_RST = 8'd10;
  localparam logic [2:0] AGE_SHIFT_RST    = 3'd2;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_SLEEP   = 3'd3,
    OP_UNBLOCK = 3'd4,
    OP_EXIT    = 3'd5,
    OP_DESTROY = 3'd6,
    OP_YIELD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_ZOMBIE  = 2'd3
  } task_st_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_NOP      = 3'd0,
    CMD_CREATE   = 3'd1,
    CMD_SET      = 3'd2,
    CMD_FREE     = 3'd3,
    CMD_SLEEP    = 3'd4,
    CMD_DISPATCH = 3'd5,
    CMD_AGE      = 3'd6
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [SLOT_W-1:0]   sel;
    logic [SLOT_W-1:0]   sel2;
    logic                prev_valid;
    task_st_t            status;
    logic [PRIO_W-1:0]   prio;
    logic [TIME_W-1:0]   tval;
  } cell_ctl_t;

  // best-candidate record passed along the chain
  typedef struct packed {
    logic                any;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [EFF_W-1:0]    eff;
  } chain_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [SLOT_W-1:0]   slot;
    logic [PRIO_W-1:0]   base_priority;
    logic [TIME_W-1:0]   sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   running_slot;
    logic                has_running;
    logic                switched;
    logic [TIME_W-1:0]   tick_now;
    logic                status;
  } out_item_t;

endpackage

[rtl/apts_cell.sv]
// ----------------------------------------------------------------------------
// apts_cell
// One task slot: holds its state and passes the best candidate onward.
// ----------------------------------------------------------------------------
module apts_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  apts_pkg::cell_ctl_t ctl,
  input  logic [2:0]         age_shift,
  input  apts_pkg::chain_t   chain_in,
  output apts_pkg::chain_t   chain_out,
  output logic               hit
);

  localparam logic [8:0] IDX_L = 9'(IDX);

  logic                          used_r, used_nxt;
  apts_pkg::task_st_t            st_r, st_nxt;
  logic [apts_pkg::PRIO_W-1:0]   prio_r, prio_nxt;
  logic [apts_pkg::TIME_W-1:0]   age_r, age_nxt;
  logic [apts_pkg::TIME_W-1:0]   wake_r, wake_nxt;
  apts_pkg::chain_t              chain_r, chain_nxt;
  logic                          m_sel, m_sel2;
  logic [apts_pkg::EFF_W-1:0]    eff;

  assign m_sel  = (IDX_L == 9'(ctl.sel));
  assign m_sel2 = (IDX_L == 9'(ctl.sel2));
  assign hit    = used_r && m_sel;
  assign eff    = apts_pkg::EFF_W'(prio_r) + apts_pkg::EFF_W'(age_r >> age_shift);

  // slot state update
  always_comb begin
    used_nxt = used_r;
    st_nxt   = st_r;
    prio_nxt = prio_r;
    age_nxt  = age_r;
    wake_nxt = wake_r;
    unique case (ctl.cmd)
      apts_pkg::CMD_CREATE: begin
        if (m_sel) begin
          used_nxt = 1'b1;
          st_nxt   = apts_pkg::ST_READY;
          prio_nxt = ctl.prio;
          age_nxt  = '0;
          wake_nxt = '0;
        end
      end
      apts_pkg::CMD_SET: begin
        if (m_sel) st_nxt = ctl.status;
      end
      apts_pkg::CMD_FREE: begin
        if (m_sel) begin
          used_nxt = 1'b0;
          st_nxt   = apts_pkg::ST_READY;
        end
      end
      apts_pkg::CMD_SLEEP: begin
        if (m_sel) begin
          st_nxt   = apts_pkg::ST_BLOCKED;
          wake_nxt = ctl.tval;
        end
      end
      apts_pkg::CMD_DISPATCH: begin
        if (ctl.prev_valid && m_sel && st_r == apts_pkg::ST_RUNNING)
          st_nxt = apts_pkg::ST_READY;
        if (m_sel2) begin
          st_nxt  = apts_pkg::ST_RUNNING;
          age_nxt = '0;
        end
      end
      apts_pkg::CMD_AGE: begin
        if (used_r) begin
          if (st_r == apts_pkg::ST_READY && age_r != '1) age_nxt = age_r + 1'b1;
          if (st_r == apts_pkg::ST_BLOCKED && wake_r != '0 && ctl.tval >= wake_r) begin
            wake_nxt = '0;
            st_nxt   = apts_pkg::ST_READY;
          end
        end
      end
      default: ;
    endcase
  end

  // candidate compare against the upstream best
  always_comb begin
    chain_nxt     = chain_in;
    chain_nxt.any = chain_in.any | used_r;
    if (used_r && st_r == apts_pkg::ST_READY && (!chain_in.found || eff > chain_in.eff)) begin
      chain_nxt.found = 1'b1;
      chain_nxt.slot  = apts_pkg::SLOT_W'(IDX);
      chain_nxt.eff   = eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      st_r   <= apts_pkg::ST_READY;
    end else begin
      used_r <= used_nxt;
      st_r   <= st_nxt;
    end
    prio_r  <= prio_nxt;
    age_r   <= age_nxt;
    wake_r  <= wake_nxt;
    chain_r <= chain_nxt;
  end

  assign chain_out = chain_r;

endmodule

[rtl/aging_priority_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// aging_priority_task_scheduler_top
// Task scheduler over a row of slot cells with aging priority pick.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one item (op, slot, base_priority, sleep_ticks).
//   out_valid/out_stall returns exactly one result item per input item.
//   cfg_we/cfg_index/cfg_wdata write slice_reload (0) and age_shift (1);
//   write only while no item is in flight.
// Sequence:
//   create, unblock, exit, destroy: execute, write the result.
//   Yield, and block or sleep with a current task: execute, scan, dispatch,
//   write; block or sleep with none: execute, write. A tick that reschedules
//   executes, scans, dispatches and ages; other ticks execute and age.
//   The best-candidate record moves one cell per cycle down the chain.
//   One item is worked on at a time; the next is taken once the result is
//   written to the output register, even if that result is still stalled.
// Reset:
//   all slots free, no current task, tick count zero, registers to defaults.
// Stall:
//   a stalled result holds; a finished item then waits before loading it.
// ----------------------------------------------------------------------------
module aging_priority_task_scheduler_top #(
  parameter int NUM_TASKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  apts_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output apts_pkg::out_item_t   out_item,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [apts_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(NUM_TASKS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_SCAN = 6'b000100,
    S_DISP = 6'b001000,
    S_AGE  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  apts_pkg::in_item_t            item_r, item_nxt;
  logic                          was_valid_r, was_valid_nxt;
  logic [apts_pkg::SLOT_W-1:0]   was_slot_r, was_slot_nxt;
  logic                          st_r, st_nxt;
  logic [apts_pkg::SLOT_W-1:0]   cur_r, cur_nxt;
  logic                          cur_valid_r, cur_valid_nxt;
  logic [7:0]                    slice_r, slice_nxt;
  logic [apts_pkg::TIME_W-1:0]   tick_r, tick_nxt;
  logic [7:0]                    slice_reload_r;
  logic [2:0]                    age_shift_r;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  apts_pkg::out_item_t           out_r, out_nxt;
  apts_pkg::cell_ctl_t           ctl;
  apts_pkg::chain_t              chain [NUM_TASKS+1];
  logic [NUM_TASKS-1:0]          hits;
  logic                          slot_hit;
  logic                          in_range;
  logic [7:0]                    slice_dec;
  apts_pkg::op_t                 op;

  assign op       = apts_pkg::op_t'(item_r.op);
  assign slot_hit = |hits;
  assign in_range = 9'(item_r.slot) < 9'(NUM_TASKS);
  assign slice_dec = (slice_r != 8'd0) ? slice_r - 8'd1 : 8'd0;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // row of slot cells
  assign chain[0] = '0;
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    apts_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .age_shift (age_shift_r),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .hit       (hits[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    was_valid_nxt = was_valid_r;
    was_slot_nxt  = was_slot_r;
    st_nxt        = st_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    slice_nxt     = slice_r;
    tick_nxt      = tick_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ctl           = '0;
    ctl.cmd       = apts_pkg::CMD_NOP;
    ctl.status    = apts_pkg::ST_READY;
    ctl.sel       = item_r.slot;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_item;
          was_valid_nxt = cur_valid_r;
          was_slot_nxt  = cur_r;
          st_nxt        = 1'b0;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cnt_nxt   = '0;
        state_nxt = S_DONE;
        unique case (op)
          apts_pkg::OP_TICK: begin
            tick_nxt  = tick_r + 1'b1;
            state_nxt = S_AGE;
            if (cur_valid_r) begin
              slice_nxt = slice_dec;
              if (slice_dec == 8'd0) state_nxt = S_SCAN;
            end
          end
          apts_pkg::OP_CREATE: begin
            if (!in_range || slot_hit) st_nxt = 1'b1;
            else begin
              ctl.cmd  = apts_pkg::CMD_CREATE;
              ctl.prio = item_r.base_priority;
            end
          end
          apts_pkg::OP_BLOCK, apts_pkg::OP_SLEEP: begin
            ctl.sel = cur_r;
            if (!cur_valid_r) st_nxt = 1'b1;
            else begin
              state_nxt = S_SCAN;
              if (op == apts_pkg::OP_SLEEP) begin
                ctl.cmd  = apts_pkg::CMD_SLEEP;
                ctl.tval = tick_r + item_r.sleep_ticks;
              end else begin
                ctl.cmd    = apts_pkg::CMD_SET;
                ctl.status = apts_pkg::ST_BLOCKED;
              end
            end
          end
          apts_pkg::OP_UNBLOCK, apts_pkg::OP_EXIT: begin
            if (!slot_hit) st_nxt = 1'b1;
            else begin
              ctl.cmd    = apts_pkg::CMD_SET;
              ctl.status = (op == apts_pkg::OP_EXIT) ? apts_pkg::ST_ZOMBIE
                                                     : apts_pkg::ST_READY;
            end
          end
          apts_pkg::OP_DESTROY: begin
            if (!slot_hit) st_nxt = 1'b1;
            else begin
              ctl.cmd = apts_pkg::CMD_FREE;
              if (cur_valid_r && cur_r == item_r.slot) cur_valid_nxt = 1'b0;
            end
          end
          apts_pkg::OP_YIELD: state_nxt = S_SCAN;
          default: ;
        endcase
      end
      S_SCAN: begin
        // wait for the record to reach the last cell
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_TASKS - 1)) state_nxt = S_DISP;
      end
      S_DISP: begin
        state_nxt = (op == apts_pkg::OP_TICK) ? S_AGE : S_DONE;
        if (chain[NUM_TASKS].any && chain[NUM_TASKS].found) begin
          ctl.cmd        = apts_pkg::CMD_DISPATCH;
          ctl.sel        = cur_r;
          ctl.prev_valid = cur_valid_r;
          ctl.sel2       = chain[NUM_TASKS].slot;
          cur_nxt        = chain[NUM_TASKS].slot;
          cur_valid_nxt  = 1'b1;
          slice_nxt      = slice_reload_r;
        end
      end
      S_AGE: begin
        ctl.cmd   = apts_pkg::CMD_AGE;
        ctl.tval  = tick_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.running_slot = cur_valid_r ? cur_r : '0;
          out_nxt.has_running  = cur_valid_r;
          out_nxt.switched     = (was_valid_r != cur_valid_r) ||
                                 (cur_valid_r && was_slot_r != cur_r);
          out_nxt.tick_now     = tick_r;
          out_nxt.status       = st_r;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cur_r          <= '0;
      cur_valid_r    <= 1'b0;
      slice_r        <= '0;
      tick_r         <= '0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      slice_reload_r <= apts_pkg::SLICE_RELOAD_RST;
      age_shift_r    <= apts_pkg::AGE_SHIFT_RST;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      slice_r     <= slice_nxt;
      tick_r      <= tick_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          apts_pkg::CFG_SLICE_RELOAD: slice_reload_r <= cfg_wdata;
          apts_pkg::CFG_AGE_SHIFT:    age_shift_r    <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
    item_r      <= item_nxt;
    was_valid_r <= was_valid_nxt;
    was_slot_r  <= was_slot_nxt;
    st_r        <= st_nxt;
    out_r       <= out_nxt;
  end

endmodule

[rtl/apts_checker.sv]
// ----------------------------------------------------------------------------
// apts_checker
// Port-level checks for the aging priority task scheduler.
// ----------------------------------------------------------------------------
`include "aging_priority_task_scheduler_top_assert.svh"

module apts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input apts_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input apts_pkg::out_item_t out_item,
  input logic                cfg_we
);

  // no current task reports slot zero
  `APTS_ASSERT_IMP(a_idle_slot, out_valid && !out_item.has_running, out_item.running_slot == '0)

  // one item at a time: busy right after an accept
  `APTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // stalled result holds
  `APTS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // stalled input item holds
  `APTS_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))

  // register writes only while idle
  `APTS_ASSERT_IMP(a_cfg_idle, cfg_we, !in_stall)

endmodule

bind aging_priority_task_scheduler_top apts_checker u_apts_checker (.*);
